### hw/rtl/pfe_pkg.sv
// shared types and constants for the postfix expression evaluator
// no dependencies; imported by every module of the block
`default_nettype none

package pfe_pkg;

  localparam int STACK_DEPTH   = 64;
  localparam int FRACTION_BITS = 16;
  localparam int VALUE_W       = 32;
  localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W        = $clog2(STACK_DEPTH);
  localparam int DIV_W         = VALUE_W + FRACTION_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_W + 1);

  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_OPER   = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_SATURATE  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_OPER,
    CMD_FINISH
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_OPER,
    BK_MUL,
    BK_DIV
  } back_state_e;

  typedef struct packed {
    logic [1:0]                action;
    logic [1:0]                operator_code;
    logic signed [VALUE_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [2:0]                status;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e                 kind;
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/pfe_front.sv
// front end: accepts tokens, drops unused action codes, queues decoded commands
// depends on pfe_pkg
`default_nettype none

module pfe_front import pfe_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t item,
  output logic          cmd_valid,
  output cmd_t          cmd,
  input  wire logic     cmd_ready
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       take;
  logic       give;
  logic       keep;
  cmd_t       decoded;

  always_comb begin
    decoded.op    = op_e'(item.operator_code);
    decoded.value = item.operand_value;
    keep          = 1'b1;
    unique case (action_e'(item.action))
      ACT_PUSH:   decoded.kind = CMD_PUSH;
      ACT_OPER:   decoded.kind = CMD_OPER;
      ACT_FINISH: decoded.kind = CMD_FINISH;
      default: begin
        decoded.kind = CMD_PUSH;
        keep         = 1'b0;
      end
    endcase
  end

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign take      = push && !full && keep;
  assign give      = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (take) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (take) wr_ptr <= ~wr_ptr;
      if (give) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, take} - {1'b0, give};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pfe_div.sv
// iterative fixed-point divider, one quotient bit per cycle, with saturation
// depends on pfe_pkg
`default_nettype none

module pfe_div import pfe_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic signed [VALUE_W-1:0] num,
  input  wire logic signed [VALUE_W-1:0] den,
  output logic                           done,
  output logic signed [VALUE_W-1:0]      quot,
  output logic                           sat
);

  localparam logic [DIV_W-1:0] POS_LIM = DIV_W'({1'b0, VAL_MAX});
  localparam logic [DIV_W-1:0] NEG_LIM = POS_LIM + DIV_W'(1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] steps;
  logic [DIV_W-1:0]     dividend;
  logic [DIV_W-1:0]     q;
  logic [VALUE_W-1:0]   rem;
  logic [VALUE_W-1:0]   dmag;
  logic                 neg;
  logic [VALUE_W-1:0]   nmag;
  logic [VALUE_W:0]     rem_sh;
  logic                 fits;
  logic [VALUE_W-1:0]   q_neg;

  assign nmag   = num[VALUE_W-1] ? (~num + VALUE_W'(1)) : num;
  assign rem_sh = {rem, dividend[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= DIV_W'(nmag) << FRACTION_BITS;
      dmag     <= den[VALUE_W-1] ? (~den + VALUE_W'(1)) : den;
      neg      <= num[VALUE_W-1] ^ den[VALUE_W-1];
      rem      <= '0;
      q        <= '0;
    end else if (busy && steps != '0) begin
      dividend <= dividend << 1;
      q        <= {q[DIV_W-2:0], fits};
      rem      <= fits ? VALUE_W'(rem_sh - {1'b0, dmag}) : rem_sh[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= DIV_CNT_W'(DIV_W);
    end else if (busy) begin
      if (steps == '0) busy <= 1'b0;
      else steps <= steps - DIV_CNT_W'(1);
    end
  end

  assign done  = busy && (steps == '0);
  assign q_neg = ~q[VALUE_W-1:0] + VALUE_W'(1);

  always_comb begin
    if (neg) begin
      sat  = q > NEG_LIM;
      quot = sat ? VAL_MIN : q_neg;
    end else begin
      sat  = q > POS_LIM;
      quot = sat ? VAL_MAX : q[VALUE_W-1:0];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pfe_back.sv
// back end: value stack, arithmetic sequencer and result register
// depends on pfe_pkg and pfe_div
`default_nettype none

module pfe_back import pfe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  input  wire cmd_t      cmd,
  output logic           cmd_ready,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      result
);

  // top of stack lives in tos, the entries below it in the memory
  logic signed [VALUE_W-1:0] mem [STACK_DEPTH];
  logic signed [VALUE_W-1:0] rd_data;
  logic signed [VALUE_W-1:0] tos;
  logic [CNT_W-1:0]          cnt;
  status_e                   err;
  op_e                       op;
  logic signed [2*VALUE_W-1:0] prod;
  back_state_e               state;
  back_state_e               state_next;
  logic                      out_valid;

  logic [CNT_W-1:0]          cnt_m1;
  logic [CNT_W-1:0]          cnt_m2;
  logic                      is_full;
  logic                      few;
  logic                      mem_we;
  logic                      div_start;
  logic                      div_done;
  logic                      div_sat;
  logic signed [VALUE_W-1:0] div_q;
  logic signed [VALUE_W:0]   sum;
  logic signed [2*VALUE_W-1:0] prod_sh;
  logic signed [VALUE_W-1:0] arith;
  logic                      arith_sat;

  assign cnt_m1  = cnt - CNT_W'(1);
  assign cnt_m2  = cnt - CNT_W'(2);
  assign is_full = (cnt == CNT_W'(STACK_DEPTH));
  assign few     = (cnt < CNT_W'(2));
  assign empty   = !out_valid;
  assign mem_we  = (state == BK_IDLE) && cmd_valid && (cmd.kind == CMD_PUSH)
                   && !is_full && (cnt != '0);

  always_ff @(posedge clk) begin
    if (mem_we) mem[cnt_m1[ADDR_W-1:0]] <= tos;
    rd_data <= mem[cnt_m2[ADDR_W-1:0]];
  end

  pfe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rd_data),
    .den   (tos),
    .done  (div_done),
    .quot  (div_q),
    .sat   (div_sat)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:
        if (cmd_valid && cmd.kind == CMD_OPER && !few) state_next = BK_OPER;
      BK_OPER:
        if (op == OP_MUL) state_next = BK_MUL;
        else if (op == OP_DIV && tos != '0) state_next = BK_DIV;
        else state_next = BK_IDLE;
      BK_MUL:
        state_next = BK_IDLE;
      BK_DIV:
        if (div_done) state_next = BK_IDLE;
      default:
        state_next = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_ready = 1'b0;
    div_start = 1'b0;
    unique case (state)
      BK_IDLE: cmd_ready = !(cmd.kind == CMD_FINISH && out_valid);
      BK_OPER: div_start = (op == OP_DIV) && (tos != '0);
      BK_MUL:  cmd_ready = 1'b0;
      BK_DIV:  cmd_ready = 1'b0;
      default: cmd_ready = 1'b0;
    endcase
  end

  // arithmetic result of the current step with saturation
  always_comb begin
    sum       = (op == OP_SUB) ? (VALUE_W+1)'(rd_data) - (VALUE_W+1)'(tos)
                               : (VALUE_W+1)'(rd_data) + (VALUE_W+1)'(tos);
    prod_sh   = prod >>> FRACTION_BITS;
    arith     = '0;
    arith_sat = 1'b0;
    unique case (state)
      BK_OPER: begin
        if (op == OP_DIV) begin
          arith = rd_data[VALUE_W-1] ? VAL_MIN : VAL_MAX;
        end else if (sum > (VALUE_W+1)'(VAL_MAX)) begin
          arith = VAL_MAX; arith_sat = 1'b1;
        end else if (sum < (VALUE_W+1)'(VAL_MIN)) begin
          arith = VAL_MIN; arith_sat = 1'b1;
        end else begin
          arith = sum[VALUE_W-1:0];
        end
      end
      BK_MUL: begin
        if (prod_sh > (2*VALUE_W)'(VAL_MAX)) begin
          arith = VAL_MAX; arith_sat = 1'b1;
        end else if (prod_sh < (2*VALUE_W)'(VAL_MIN)) begin
          arith = VAL_MIN; arith_sat = 1'b1;
        end else begin
          arith = prod_sh[VALUE_W-1:0];
        end
      end
      BK_DIV: begin
        arith     = div_q;
        arith_sat = div_sat;
      end
      default: arith = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && cmd_valid && cmd_ready) begin
      op <= cmd.op;
      if (cmd.kind == CMD_PUSH && !is_full) tos <= cmd.value;
      if (cmd.kind == CMD_FINISH) begin
        result.result_value <= (cnt != '0) ? tos : '0;
        result.status <= (err == ST_OK && cnt == '0) ? ST_UNDERFLOW : err;
      end
    end
    if (state == BK_OPER) prod <= rd_data * tos;
    if ((state == BK_OPER && op != OP_MUL && !(op == OP_DIV && tos != '0)) ||
        state == BK_MUL || (state == BK_DIV && div_done)) begin
      tos <= arith;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      cnt       <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && out_valid) out_valid <= 1'b0;
      priority case (state)
        BK_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            unique case (cmd.kind)
              CMD_PUSH: begin
                if (is_full) begin
                  if (err == ST_OK) err <= ST_OVERFLOW;
                end else begin
                  cnt <= cnt + CNT_W'(1);
                end
              end
              CMD_OPER: begin
                if (few && err == ST_OK) err <= ST_UNDERFLOW;
              end
              CMD_FINISH: begin
                cnt       <= '0;
                err       <= ST_OK;
                out_valid <= 1'b1;
              end
              default: cnt <= cnt;
            endcase
          end
        end
        BK_OPER: begin
          if (op == OP_DIV && tos == '0) begin
            cnt <= cnt_m1;
            if (err == ST_OK) err <= ST_DIVZERO;
          end else if (op == OP_ADD || op == OP_SUB) begin
            cnt <= cnt_m1;
            if (arith_sat && err == ST_OK) err <= ST_SATURATE;
          end
        end
        BK_MUL, BK_DIV: begin
          if (state == BK_MUL || div_done) begin
            cnt <= cnt_m1;
            if (arith_sat && err == ST_OK) err <= ST_SATURATE;
          end
        end
        default: cnt <= cnt;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_oper_two: assert property (@(posedge clk) disable iff (rst)
    (state == BK_OPER) |-> (cnt >= CNT_W'(2)))
    else $error("operator started with fewer than two values");

  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    (state == BK_IDLE && cmd_valid && cmd_ready && cmd.kind == CMD_FINISH)
      |=> (out_valid && cnt == '0 && err == ST_OK))
    else $error("finish did not load result and clear stack");

endmodule

`default_nettype wire

### hw/rtl/postfix_expression_evaluator.sv
// Postfix (RPN) calculator over signed Q16.16 values, one token per request.
// A front queue of two decoded tokens decouples input from the execution
// unit. Push and finish are handled in idle; add and subtract pass through
// OPER, multiply through OPER and MUL, divide through OPER and DIV, where the
// divider forms one quotient bit per cycle over a 48-bit scaled dividend.
// A finish token yields one result in a one-entry output register.
`default_nettype none

module postfix_expression_evaluator import pfe_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t item,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     result
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  pfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  pfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire
